>>> rtl/sfpr_pkg.sv
// Shared types, constants and CRC functions of the framed packet receiver.
`timescale 1ns / 1ps

package sfpr_pkg;

    localparam int CFG_ADDR_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_VALUE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HCRC_POLY  = 1'd1;

    localparam logic [7:0]  SYNC_RESET      = 8'hA6;
    localparam logic [7:0]  HCRC_POLY_RESET = 8'h07;
    localparam logic [7:0]  HCRC_INIT       = 8'h00;
    localparam logic [15:0] FCRC_INIT       = 16'hFFFF;
    localparam logic [15:0] FCRC_POLY       = 16'h1021;
    localparam logic [15:0] ERR_COUNT_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } sfpr_kind_t;

    // CRC-8, MSB first, programmable polynomial, one byte per call.
    function automatic logic [7:0] crc8_byte(input logic [7:0] data,
                                             input logic [7:0] crc,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ poly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // CRC-16-CCITT, MSB first, one byte per call.
    function automatic logic [15:0] crc16_byte(input logic [7:0]  data,
                                               input logic [15:0] crc);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ FCRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // CRC values after the SYNC byte alone, for the reset configuration.
    localparam logic [7:0]  SYNC_HCRC_RESET = crc8_byte(SYNC_RESET, HCRC_INIT, HCRC_POLY_RESET);
    localparam logic [15:0] SYNC_FCRC_RESET = crc16_byte(SYNC_RESET, FCRC_INIT);

    typedef struct packed {
        logic [7:0]  sync_value;
        logic [7:0]  hcrc_poly;
        logic [7:0]  sync_hcrc;
        logic [15:0] sync_fcrc;
    } sfpr_cfg_t;

    typedef struct packed {
        logic        valid;
        sfpr_kind_t  kind;
        logic [6:0]  command;
        logic        ack_requested;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        logic [7:0]  frame_length;
        logic [15:0] error_count;
    } sfpr_result_t;

endpackage

>>> rtl/sfpr_cfg.sv
// Configuration registers of the framed packet receiver, with the CRCs of the SYNC byte.
`timescale 1ns / 1ps

module sfpr_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sfpr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]                      cfg_wdata,
    output sfpr_pkg::sfpr_cfg_t             cfg
);

    logic [7:0]  sync_value_reg;
    logic [7:0]  hcrc_poly_reg;
    logic [7:0]  sync_hcrc_reg;
    logic [15:0] sync_fcrc_reg;

    // The start-of-frame CRCs are refreshed with every write, so a frame
    // never has to run two CRC steps in one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg <= sfpr_pkg::SYNC_RESET;
            hcrc_poly_reg  <= sfpr_pkg::HCRC_POLY_RESET;
            sync_hcrc_reg  <= sfpr_pkg::SYNC_HCRC_RESET;
            sync_fcrc_reg  <= sfpr_pkg::SYNC_FCRC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                sfpr_pkg::REG_SYNC_VALUE:
                begin
                    sync_value_reg <= cfg_wdata;
                    sync_hcrc_reg  <= sfpr_pkg::crc8_byte(cfg_wdata, sfpr_pkg::HCRC_INIT,
                                                          hcrc_poly_reg);
                    sync_fcrc_reg  <= sfpr_pkg::crc16_byte(cfg_wdata, sfpr_pkg::FCRC_INIT);
                end
                sfpr_pkg::REG_HCRC_POLY:
                begin
                    hcrc_poly_reg <= cfg_wdata;
                    sync_hcrc_reg <= sfpr_pkg::crc8_byte(sync_value_reg, sfpr_pkg::HCRC_INIT,
                                                         cfg_wdata);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.sync_value = sync_value_reg;
    assign cfg.hcrc_poly  = hcrc_poly_reg;
    assign cfg.sync_hcrc  = sync_hcrc_reg;
    assign cfg.sync_fcrc  = sync_fcrc_reg;

endmodule

>>> rtl/sfpr_frame_fsm.sv
// Frame state machine: SYNC handling, header and frame CRC checks, result generation.
`timescale 1ns / 1ps

module sfpr_frame_fsm (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             rx_byte,
    input  sfpr_pkg::sfpr_cfg_t    cfg,
    output sfpr_pkg::sfpr_result_t result
);

    typedef enum logic [2:0] {
        PH_WAIT        = 3'd0,
        PH_CMD         = 3'd1,
        PH_SIZE        = 3'd2,
        PH_HCRC        = 3'd3,
        PH_DATA        = 3'd4,
        PH_FCRC_HI     = 3'd5,
        PH_FCRC_LO     = 3'd6,
        PH_SYNC_OR_CMD = 3'd7
    } phase_t;

    phase_t      phase_reg, phase_next;
    phase_t      saved_phase_reg, saved_phase_next;
    logic [7:0]  header_crc_reg, header_crc_next;
    logic [15:0] frame_crc_reg, frame_crc_next;
    logic [6:0]  held_command_reg, held_command_next;
    logic        held_ack_reg, held_ack_next;
    logic [7:0]  held_length_reg, held_length_next;
    logic [7:0]  received_count_reg, received_count_next;
    logic [15:0] rejected_frames_reg, rejected_frames_next;

    always_comb
    begin
        logic        is_sync;
        logic        restart;
        phase_t      run_phase;
        logic [7:0]  hcrc_base;
        logic [15:0] fcrc_base;
        logic [7:0]  hcrc_upd;
        logic [15:0] fcrc_upd;
        logic [8:0]  count_inc;
        logic        do_reject;
        logic        keep_header;
        logic        do_accept;

        phase_next           = phase_reg;
        saved_phase_next     = saved_phase_reg;
        header_crc_next      = header_crc_reg;
        frame_crc_next       = frame_crc_reg;
        held_command_next    = held_command_reg;
        held_ack_next        = held_ack_reg;
        held_length_next     = held_length_reg;
        received_count_next  = received_count_reg;
        rejected_frames_next = rejected_frames_reg;
        do_reject   = 1'b0;
        keep_header = 1'b1;
        do_accept   = 1'b0;

        result               = '0;
        result.kind          = sfpr_pkg::KIND_PAYLOAD;
        result.command       = held_command_reg;
        result.ack_requested = held_ack_reg;
        result.frame_length  = held_length_reg;

        is_sync   = (rx_byte == cfg.sync_value);
        restart   = (phase_reg == PH_SYNC_OR_CMD) && !is_sync;
        hcrc_base = restart ? cfg.sync_hcrc : header_crc_reg;
        fcrc_base = restart ? cfg.sync_fcrc : frame_crc_reg;
        hcrc_upd  = sfpr_pkg::crc8_byte(rx_byte, hcrc_base, cfg.hcrc_poly);
        fcrc_upd  = sfpr_pkg::crc16_byte(rx_byte, fcrc_base);
        count_inc = {1'b0, received_count_reg} + 9'd1;

        if (phase_reg == PH_SYNC_OR_CMD)
            run_phase = is_sync ? saved_phase_reg : PH_CMD;
        else
            run_phase = phase_reg;

        if (is_sync && !(phase_reg inside {PH_WAIT, PH_CMD, PH_SYNC_OR_CMD}))
        begin
            // Hold back a lone SYNC until the next byte says what it was.
            saved_phase_next = phase_reg;
            phase_next       = PH_SYNC_OR_CMD;
        end
        else
        begin
            if (restart)
            begin
                received_count_next = '0;
                header_crc_next     = cfg.sync_hcrc;
                frame_crc_next      = cfg.sync_fcrc;
            end

            unique case (run_phase)
                PH_CMD:
                begin
                    if (rx_byte[6:0] != 7'd0)
                    begin
                        phase_next        = PH_SIZE;
                        header_crc_next   = hcrc_upd;
                        frame_crc_next    = fcrc_upd;
                        held_command_next = rx_byte[6:0];
                        held_ack_next     = rx_byte[7];
                    end
                    else
                    begin
                        do_reject   = 1'b1;
                        keep_header = 1'b0;
                    end
                end
                PH_SIZE:
                begin
                    phase_next       = PH_HCRC;
                    header_crc_next  = hcrc_upd;
                    frame_crc_next   = fcrc_upd;
                    held_length_next = rx_byte;
                end
                PH_HCRC:
                begin
                    if (header_crc_reg != rx_byte)
                        do_reject = 1'b1;
                    else if (held_length_reg == 8'd0)
                        do_accept = 1'b1;
                    else
                    begin
                        phase_next     = PH_DATA;
                        frame_crc_next = fcrc_upd;
                    end
                end
                PH_DATA:
                begin
                    phase_next          = (count_inc < {1'b0, held_length_reg}) ?
                                          PH_DATA : PH_FCRC_HI;
                    frame_crc_next      = fcrc_upd;
                    received_count_next = count_inc[7:0];
                    result.valid        = 1'b1;
                    result.kind         = sfpr_pkg::KIND_PAYLOAD;
                    result.payload_byte = rx_byte;
                    result.byte_index   = received_count_reg;
                end
                PH_FCRC_HI:
                begin
                    if (rx_byte == frame_crc_reg[15:8])
                        phase_next = PH_FCRC_LO;
                    else
                        do_reject = 1'b1;
                end
                PH_FCRC_LO:
                begin
                    if (rx_byte == frame_crc_reg[7:0])
                        do_accept = 1'b1;
                    else
                        do_reject = 1'b1;
                end
                default:
                begin
                    if (is_sync)
                    begin
                        phase_next          = PH_CMD;
                        received_count_next = '0;
                        header_crc_next     = cfg.sync_hcrc;
                        frame_crc_next      = cfg.sync_fcrc;
                    end
                end
            endcase

            if (do_reject)
            begin
                phase_next = PH_WAIT;
                if (rejected_frames_reg != sfpr_pkg::ERR_COUNT_MAX)
                    rejected_frames_next = rejected_frames_reg + 16'd1;
                result.valid = 1'b1;
                result.kind  = sfpr_pkg::KIND_REJECT;
                if (!keep_header)
                begin
                    result.command       = '0;
                    result.ack_requested = 1'b0;
                    result.frame_length  = '0;
                end
            end
            if (do_accept)
            begin
                phase_next   = PH_WAIT;
                result.valid = 1'b1;
                result.kind  = sfpr_pkg::KIND_ACCEPT;
            end
        end

        result.error_count = rejected_frames_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_WAIT;
            saved_phase_reg     <= PH_WAIT;
            header_crc_reg      <= sfpr_pkg::HCRC_INIT;
            frame_crc_reg       <= sfpr_pkg::FCRC_INIT;
            held_command_reg    <= '0;
            held_ack_reg        <= 1'b0;
            held_length_reg     <= '0;
            received_count_reg  <= '0;
            rejected_frames_reg <= '0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            saved_phase_reg     <= saved_phase_next;
            header_crc_reg      <= header_crc_next;
            frame_crc_reg       <= frame_crc_next;
            held_command_reg    <= held_command_next;
            held_ack_reg        <= held_ack_next;
            held_length_reg     <= held_length_next;
            received_count_reg  <= received_count_next;
            rejected_frames_reg <= rejected_frames_next;
        end
    end

    // The error count only ever climbs.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> rejected_frames_reg >= $past(rejected_frames_reg))
        else $error("rejected frame count went down");

    // A payload byte always lies inside the length from the header.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.valid && result.kind == sfpr_pkg::KIND_PAYLOAD)
        |-> result.byte_index < result.frame_length)
        else $error("payload index beyond frame length");

    // A held-back SYNC always belongs to a phase past the command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SYNC_OR_CMD) |->
        (saved_phase_reg == PH_SIZE || saved_phase_reg == PH_HCRC ||
         saved_phase_reg == PH_DATA || saved_phase_reg == PH_FCRC_HI ||
         saved_phase_reg == PH_FCRC_LO))
        else $error("held SYNC with no frame phase to return to");

endmodule

>>> rtl/sync_framed_packet_receiver_unit.sv
// Top level of the framed packet receiver: request registers, configuration and frame logic.
`timescale 1ns / 1ps
// A byte taken on the slave side waits in the input register until the output register
// is free or being emptied; the frame state machine then writes any result it has there.
// Throughput: one byte per cycle while the master side does not stall; both CRCs of a byte
// are updated combinationally, and the output register frees the input side as it empties.
// Bytes that close no payload item and no frame give no request on the master side.
// Reset (rst_n, asynchronous, active low) empties both registers, restores the SYNC
// value 0xA6 and CRC-8 polynomial 0x07, and returns the receiver to waiting for SYNC.

module sync_framed_packet_receiver_unit (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration writes: register 0 is the SYNC value, register 1 the CRC-8 polynomial.
    input  logic                            cfg_we,
    input  logic [sfpr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]                      cfg_wdata,

    // Received bytes.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] rx_byte

    // Results.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [6:0] command, [7] ack_requested, [15:8] payload_byte, [23:16] byte_index,
    // [31:24] frame_length, [47:32] error_count
    output logic [47:0]                     m_tdata,
    output logic [1:0]                      m_tuser    // [1:0] kind
);

    sfpr_pkg::sfpr_cfg_t    cfg;
    sfpr_pkg::sfpr_result_t result;
    sfpr_pkg::sfpr_result_t out_res_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       step;

    sfpr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held byte is processed whenever the output register is free or being
    // emptied this cycle; bytes without a result simply retire.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    sfpr_frame_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= result.valid;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Data registers carry no reset; their valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (step && result.valid)
            out_res_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {out_res_reg.error_count,
                       out_res_reg.frame_length,
                       out_res_reg.byte_index,
                       out_res_reg.payload_byte,
                       out_res_reg.ack_requested,
                       out_res_reg.command};

    // An empty input register must always be able to take a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // A result waiting on a stalled master side must not be overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !step)
        else $error("frame logic advanced over a pending result");

endmodule
